### rtl/ismc_pkg.sv
// ----------------------------------------------------------------------------
// ismc_pkg: shared types and constants for the interrupt status/mask block
// Holds the command codes, the register map, the group levels and the
// pending-level priority function.
// ----------------------------------------------------------------------------
package ismc_pkg;

    typedef logic [31:0] t_word;
    typedef t_word t_status_arr [3];
    typedef t_word t_mask_arr [9];

    typedef enum logic [1:0] {
        CMD_READ  = 2'd0,
        CMD_WRITE = 2'd1,
        CMD_RAISE = 2'd2,
        CMD_NOP   = 2'd3
    } t_cmd;

    localparam logic [27:0] STATUS_PAGE = 28'h005F690;
    localparam logic [27:0] MASK_PAGE0  = 28'h005F691;
    localparam logic [27:0] MASK_PAGE1  = 28'h005F692;
    localparam logic [27:0] MASK_PAGE2  = 28'h005F693;
    localparam logic [3:0]  WINDOW_LAST = 4'hB;
    localparam logic [31:0] PHYS_MASK   = 32'h1FFFFFFF;
    localparam logic [31:0] FOLD_LOW    = 32'h80000000;
    localparam logic [31:0] FOLD_HIGH   = 32'hE0000000;

    localparam logic [3:0] GROUP_LEVEL [3] = '{4'd13, 4'd11, 4'd9};
    localparam logic [3:0] LEVEL_NONE = 4'd0;

    function automatic logic [3:0] pending_level(input t_status_arr st,
                                                 input t_mask_arr mk);
        logic [3:0] level;
        logic       hit;
        level = LEVEL_NONE;
        for (int g = 2; g >= 0; g--) begin
            hit = 1'b0;
            for (int s = 0; s < 3; s++) begin
                hit = hit | (|(st[s] & mk[g * 3 + s]));
            end
            if (hit) begin
                level = GROUP_LEVEL[g];
            end
        end
        return level;
    endfunction

endpackage

### rtl/interrupt_status_mask_controller.sv
// ----------------------------------------------------------------------------
// interrupt_status_mask_controller: status/mask registers with group priority
// Byte-wide register access, write-one-to-clear status, raise events and a
// registered highest-pending-level result for every beat.
// ----------------------------------------------------------------------------
//  channel  | handshake                 | payload
//  input    | i_in_valid / o_in_ready   | cmd, address, write_byte,
//           |                           | source_word, raise_bits
//  output   | o_out_valid / i_out_ready | read_data, access_error,
//           |                           | irq_pending, irq_level
//
// One beat per cycle is sustained while the output is not stalled; a result
// reaches the output through the input register, then the result register.
// The register update and the level search sit between those two registers.
// Reset is synchronous, active low, and clears all status and mask words.
// A stalled output holds its result; the input register still takes one
// more beat while the result waits.
// ----------------------------------------------------------------------------
module interrupt_status_mask_controller (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [1:0]  i_cmd,
    input  logic [31:0] i_address,
    input  logic [7:0]  i_write_byte,
    input  logic [1:0]  i_source_word,
    input  logic [31:0] i_raise_bits,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [7:0]  o_read_data,
    output logic        o_access_error,
    output logic        o_irq_pending,
    output logic [3:0]  o_irq_level
);

    logic        r_in_valid;
    logic [1:0]  r_cmd;
    logic [31:0] r_address;
    logic [7:0]  r_write_byte;
    logic [1:0]  r_source_word;
    logic [31:0] r_raise_bits;

    ismc_pkg::t_status_arr r_status;
    ismc_pkg::t_status_arr n_status;
    ismc_pkg::t_mask_arr   r_mask;
    ismc_pkg::t_mask_arr   n_mask;

    logic        r_out_valid;
    logic [7:0]  r_read_data;
    logic [7:0]  n_read_data;
    logic        r_access_error;
    logic        n_access_error;
    logic [3:0]  r_irq_level;
    logic [3:0]  n_irq_level;

    logic        in_accept;
    logic        advance;
    logic [31:0] phys;
    logic [27:0] page;
    logic        in_window;
    logic [1:0]  word_sel;
    logic [1:0]  byte_sel;
    logic        hit_status;
    logic [1:0]  mask_group;
    logic        hit_mask;
    logic [3:0]  mask_slot;
    logic [7:0]  status_byte;
    logic [7:0]  mask_byte;

    assign advance    = r_in_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready = !r_in_valid || advance;
    assign in_accept  = i_in_valid && o_in_ready;

    always_comb begin
        if (r_address >= ismc_pkg::FOLD_LOW && r_address < ismc_pkg::FOLD_HIGH) begin
            phys = r_address & ismc_pkg::PHYS_MASK;
        end else begin
            phys = r_address;
        end
    end

    assign page      = phys[31:4];
    assign in_window = phys[3:0] <= ismc_pkg::WINDOW_LAST;
    assign word_sel  = phys[3:2];
    assign byte_sel  = phys[1:0];

    always_comb begin
        hit_status = 1'b0;
        hit_mask   = 1'b0;
        mask_group = 2'd0;
        unique case (page)
            ismc_pkg::STATUS_PAGE: hit_status = in_window;
            ismc_pkg::MASK_PAGE0: begin
                hit_mask   = in_window;
                mask_group = 2'd0;
            end
            ismc_pkg::MASK_PAGE1: begin
                hit_mask   = in_window;
                mask_group = 2'd1;
            end
            ismc_pkg::MASK_PAGE2: begin
                hit_mask   = in_window;
                mask_group = 2'd2;
            end
            default: begin
                hit_status = 1'b0;
                hit_mask   = 1'b0;
            end
        endcase
    end

    assign mask_slot   = {1'b0, mask_group, 1'b0} + {2'b00, mask_group}
                       + {2'b00, word_sel};
    assign status_byte = r_status[word_sel][{byte_sel, 3'b000} +: 8];
    assign mask_byte   = r_mask[mask_slot][{byte_sel, 3'b000} +: 8];

    always_comb begin
        n_status       = r_status;
        n_mask         = r_mask;
        n_read_data    = 8'd0;
        n_access_error = 1'b0;
        unique case (ismc_pkg::t_cmd'(r_cmd))
            ismc_pkg::CMD_READ: begin
                if (hit_status) begin
                    n_read_data = status_byte;
                end else if (hit_mask) begin
                    n_read_data = mask_byte;
                end else begin
                    n_access_error = 1'b1;
                end
            end
            ismc_pkg::CMD_WRITE: begin
                if (hit_status) begin
                    n_status[word_sel][{byte_sel, 3'b000} +: 8] =
                        status_byte & ~r_write_byte;
                end else if (hit_mask) begin
                    n_mask[mask_slot][{byte_sel, 3'b000} +: 8] = r_write_byte;
                end else begin
                    n_access_error = 1'b1;
                end
            end
            ismc_pkg::CMD_RAISE: begin
                if (r_source_word != 2'd3) begin
                    n_status[r_source_word] = r_status[r_source_word] | r_raise_bits;
                end
            end
            default: begin
                n_access_error = 1'b0;
            end
        endcase
        n_irq_level = ismc_pkg::pending_level(n_status, n_mask);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_cmd         <= i_cmd;
            r_address     <= i_address;
            r_write_byte  <= i_write_byte;
            r_source_word <= i_source_word;
            r_raise_bits  <= i_raise_bits;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int s = 0; s < 3; s++) begin
                r_status[s] <= '0;
            end
            for (int m = 0; m < 9; m++) begin
                r_mask[m] <= '0;
            end
        end else if (advance) begin
            r_status <= n_status;
            r_mask   <= n_mask;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_read_data    <= n_read_data;
            r_access_error <= n_access_error;
            r_irq_level    <= n_irq_level;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_read_data    = r_read_data;
    assign o_access_error = r_access_error;
    assign o_irq_level    = r_irq_level;
    assign o_irq_pending  = r_irq_level != ismc_pkg::LEVEL_NONE;

`ifndef SYNTHESIS
    a_error_reads_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_access_error |-> o_read_data == 8'd0)
        else $error("access error beat carries nonzero read data");

    a_level_legal: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_irq_level == 4'd0 || o_irq_level == 4'd9 ||
                         o_irq_level == 4'd11 || o_irq_level == 4'd13))
        else $error("irq level is not a group level");

    a_raise_sets_bits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        advance && r_cmd == ismc_pkg::CMD_RAISE && r_source_word == 2'd0
        |=> (r_status[0] & $past(r_raise_bits)) == $past(r_raise_bits))
        else $error("raise beat did not set status bits");
`endif

endmodule

### bench/tb.sv
// ----------------------------------------------------------------------------
// tb: self-checking bench for interrupt_status_mask_controller
// Drives byte reads, byte writes, raise events and no-ops through the input
// channel and compares every result beat against a scoreboard that keeps its
// own copy of the status and mask words. A directed set covers the register
// map edges, address aliases and unimplemented addresses. Random traffic then
// runs in four phases with different sender idling and receiver stalling.
// ----------------------------------------------------------------------------
module tb;

    localparam logic [31:0] STATUS_ADDR = 32'h005F_6900;
    localparam logic [31:0] REGISTER_PAGE [4] =
        '{32'h005F_6900, 32'h005F_6910, 32'h005F_6920, 32'h005F_6930};
    localparam logic [3:0] LEVEL_OF_GROUP [3] = '{4'd13, 4'd11, 4'd9};
    localparam int PHASE_BEATS = 500;
    localparam int CYCLE_LIMIT = 200000;

    typedef struct packed {
        logic [7:0] read_data;
        logic       access_error;
        logic       irq_pending;
        logic [3:0] irq_level;
    } t_irq_result;

    class t_irq_scoreboard;
        logic [31:0] status_word [3];
        logic [31:0] mask_word [9];
        t_irq_result pending_results [$];
        int          failures;
        int          checked;

        function new();
            foreach (status_word[i]) status_word[i] = '0;
            foreach (mask_word[i]) mask_word[i] = '0;
            failures = 0;
            checked  = 0;
        endfunction

        function int decode_register(logic [31:0] phys);
            int idx;
            idx = -1;
            if (phys >= STATUS_ADDR && phys <= STATUS_ADDR + 32'd11) begin
                idx = int'((phys - STATUS_ADDR) >> 2);
            end
            for (int g = 0; g < 3; g++) begin
                if (phys >= REGISTER_PAGE[g + 1] &&
                    phys <= REGISTER_PAGE[g + 1] + 32'd11) begin
                    idx = 3 + g * 3 + int'((phys - REGISTER_PAGE[g + 1]) >> 2);
                end
            end
            return idx;
        endfunction

        function logic [3:0] highest_level();
            for (int g = 0; g < 3; g++) begin
                for (int s = 0; s < 3; s++) begin
                    if ((status_word[s] & mask_word[g * 3 + s]) != '0) begin
                        return LEVEL_OF_GROUP[g];
                    end
                end
            end
            return ismc_pkg::LEVEL_NONE;
        endfunction

        function void note_beat(ismc_pkg::t_cmd cmd, logic [31:0] addr, logic [7:0] wbyte,
                                logic [1:0] src, logic [31:0] bits);
            logic [31:0] phys;
            logic [31:0] word;
            int          idx;
            int          shift;
            t_irq_result res;
            phys  = (addr >= ismc_pkg::FOLD_LOW && addr < ismc_pkg::FOLD_HIGH) ?
                    (addr & ismc_pkg::PHYS_MASK) : addr;
            shift = 8 * int'(phys[1:0]);
            res   = '0;
            if (cmd == ismc_pkg::CMD_READ || cmd == ismc_pkg::CMD_WRITE) begin
                idx = decode_register(phys);
                if (idx < 0) begin
                    res.access_error = 1'b1;
                end else if (cmd == ismc_pkg::CMD_READ) begin
                    word = (idx < 3) ? status_word[idx] : mask_word[idx - 3];
                    res.read_data = word[shift +: 8];
                end else if (idx < 3) begin
                    status_word[idx][shift +: 8] = status_word[idx][shift +: 8] & ~wbyte;
                end else begin
                    mask_word[idx - 3][shift +: 8] = wbyte;
                end
            end else if (cmd == ismc_pkg::CMD_RAISE && src != 2'd3) begin
                status_word[src] = status_word[src] | bits;
            end
            res.irq_level   = highest_level();
            res.irq_pending = (res.irq_level != ismc_pkg::LEVEL_NONE);
            pending_results.push_back(res);
        endfunction

        function void check_result(t_irq_result got);
            t_irq_result want;
            if (pending_results.size() == 0) begin
                $error("result beat with nothing expected: read_data %0h error %0b level %0d",
                       got.read_data, got.access_error, got.irq_level);
                failures++;
                return;
            end
            want = pending_results.pop_front();
            checked++;
            if (got.read_data !== want.read_data) begin
                $error("read_data: expected %0h, actual %0h", want.read_data, got.read_data);
                failures++;
            end
            if (got.access_error !== want.access_error) begin
                $error("access_error: expected %0b, actual %0b",
                       want.access_error, got.access_error);
                failures++;
            end
            if (got.irq_pending !== want.irq_pending) begin
                $error("irq_pending: expected %0b, actual %0b", want.irq_pending, got.irq_pending);
                failures++;
            end
            if (got.irq_level !== want.irq_level) begin
                $error("irq_level: expected %0d, actual %0d", want.irq_level, got.irq_level);
                failures++;
            end
        endfunction
    endclass

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_in_valid = 1'b0;
    logic        o_in_ready;
    logic [1:0]  i_cmd = '0;
    logic [31:0] i_address = '0;
    logic [7:0]  i_write_byte = '0;
    logic [1:0]  i_source_word = '0;
    logic [31:0] i_raise_bits = '0;
    logic        o_out_valid;
    logic        i_out_ready = 1'b0;
    logic [7:0]  o_read_data;
    logic        o_access_error;
    logic        o_irq_pending;
    logic [3:0]  o_irq_level;

    t_irq_scoreboard sb = new();
    int              send_idle_pct = 0;
    int              recv_stall_pct = 0;
    int              cmd_count [4] = '{0, 0, 0, 0};
    int              cycles = 0;

    interrupt_status_mask_controller u_top (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_ready     (o_in_ready),
        .i_cmd          (i_cmd),
        .i_address      (i_address),
        .i_write_byte   (i_write_byte),
        .i_source_word  (i_source_word),
        .i_raise_bits   (i_raise_bits),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .o_read_data    (o_read_data),
        .o_access_error (o_access_error),
        .o_irq_pending  (o_irq_pending),
        .o_irq_level    (o_irq_level)
    );

    always #5 i_clk = ~i_clk;

    always @(negedge i_clk) begin
        i_out_ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready) begin
            sb.check_result(t_irq_result'{o_read_data, o_access_error, o_irq_pending,
                                          o_irq_level});
        end
    end

    // Called just after a falling edge; returns just after the falling edge
    // that follows acceptance, with valid still high.
    task automatic send_beat(ismc_pkg::t_cmd cmd, logic [31:0] addr, logic [7:0] wbyte,
                             logic [1:0] src, logic [31:0] bits);
        while ($urandom_range(99) < send_idle_pct) begin
            i_in_valid = 1'b0;
            @(negedge i_clk);
        end
        i_in_valid    = 1'b1;
        i_cmd         = cmd;
        i_address     = addr;
        i_write_byte  = wbyte;
        i_source_word = src;
        i_raise_bits  = bits;
        do @(posedge i_clk); while (!o_in_ready);
        sb.note_beat(cmd, addr, wbyte, src, bits);
        cmd_count[cmd]++;
        @(negedge i_clk);
    endtask

    task automatic drain_results();
        i_in_valid = 1'b0;
        while (sb.pending_results.size() != 0) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    function automatic logic [31:0] random_address();
        logic [31:0] addr;
        int          page;
        page = $urandom_range(3);
        case ($urandom_range(9))
            0: addr = $urandom();
            1: addr = REGISTER_PAGE[page] + $urandom_range(12, 15);
            default: addr = REGISTER_PAGE[page] + $urandom_range(11);
        endcase
        case ($urandom_range(7))
            4: addr = addr | 32'h8000_0000;
            5: addr = addr | 32'hA000_0000;
            6: addr = addr | 32'hC000_0000;
            7: addr = addr | ($urandom_range(1) ? 32'hE000_0000 : 32'h2000_0000);
            default: ;
        endcase
        return addr;
    endfunction

    task automatic send_random_beat();
        int             pick;
        ismc_pkg::t_cmd cmd;
        logic [31:0]    bits;
        pick = $urandom_range(99);
        cmd  = (pick < 35) ? ismc_pkg::CMD_READ : (pick < 70) ? ismc_pkg::CMD_WRITE :
               (pick < 95) ? ismc_pkg::CMD_RAISE : ismc_pkg::CMD_NOP;
        bits = $urandom();
        case ($urandom_range(3))
            0: bits = bits & $urandom() & $urandom();
            1: bits = 32'd1 << $urandom_range(31);
            default: ;
        endcase
        send_beat(cmd, random_address(), 8'($urandom()), 2'($urandom_range(3)), bits);
    endtask

    initial begin
        while (cycles < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycles++;
        end
        $display("interrupt_status_mask_controller verification failed");
        $finish;
    end

    initial begin
        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        send_beat(ismc_pkg::CMD_READ,  32'h0000_0000, 8'h00, 2'd0, 32'h0000_0000);
        send_beat(ismc_pkg::CMD_WRITE, 32'hFFFF_FFFF, 8'hFF, 2'd3, 32'hFFFF_FFFF);
        send_beat(ismc_pkg::CMD_RAISE, 32'h0000_0000, 8'h00, 2'd0, 32'hFFFF_FFFF);
        send_beat(ismc_pkg::CMD_RAISE, 32'h005F_6900, 8'hFF, 2'd1, 32'h0000_FF00);
        send_beat(ismc_pkg::CMD_RAISE, 32'h0000_0000, 8'h00, 2'd2, 32'hFF00_0000);
        send_beat(ismc_pkg::CMD_RAISE, 32'h0000_0000, 8'h00, 2'd3, 32'hFFFF_FFFF);
        send_beat(ismc_pkg::CMD_READ,  32'h005F_6900, 8'h00, 2'd0, 32'h0000_0000);
        send_beat(ismc_pkg::CMD_READ,  32'h805F_6903, 8'h00, 2'd0, 32'h0000_0000);
        send_beat(ismc_pkg::CMD_READ,  32'hA05F_6905, 8'h00, 2'd0, 32'h0000_0000);
        send_beat(ismc_pkg::CMD_WRITE, 32'h005F_6930, 8'h01, 2'd0, 32'h0000_0000);
        send_beat(ismc_pkg::CMD_WRITE, 32'hC05F_6925, 8'h80, 2'd0, 32'h0000_0000);
        send_beat(ismc_pkg::CMD_WRITE, 32'h005F_691B, 8'hFF, 2'd0, 32'h0000_0000);
        send_beat(ismc_pkg::CMD_READ,  32'hC05F_691B, 8'h00, 2'd0, 32'h0000_0000);
        send_beat(ismc_pkg::CMD_READ,  32'h005F_690C, 8'h00, 2'd0, 32'h0000_0000);
        send_beat(ismc_pkg::CMD_READ,  32'hE05F_6910, 8'h00, 2'd0, 32'h0000_0000);
        send_beat(ismc_pkg::CMD_WRITE, 32'h205F_6930, 8'h00, 2'd0, 32'h0000_0000);
        send_beat(ismc_pkg::CMD_NOP,   32'h005F_6900, 8'hFF, 2'd0, 32'hFFFF_FFFF);
        send_beat(ismc_pkg::CMD_WRITE, 32'h005F_690B, 8'hFF, 2'd0, 32'h0000_0000);
        send_beat(ismc_pkg::CMD_WRITE, 32'h805F_6905, 8'hFF, 2'd0, 32'h0000_0000);
        send_beat(ismc_pkg::CMD_WRITE, 32'h005F_6900, 8'h01, 2'd0, 32'h0000_0000);
        send_beat(ismc_pkg::CMD_READ,  32'h005F_6900, 8'h00, 2'd0, 32'h0000_0000);
        send_beat(ismc_pkg::CMD_READ,  32'hDFFF_FFFF, 8'h00, 2'd0, 32'h0000_0000);
        send_beat(ismc_pkg::CMD_READ,  32'h005F_693B, 8'h00, 2'd0, 32'h0000_0000);
        send_beat(ismc_pkg::CMD_READ,  32'h005F_68FF, 8'h00, 2'd0, 32'h0000_0000);
        drain_results();

        for (int phase = 0; phase < 4; phase++) begin
            case (phase)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 59; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 59; end
                default: begin send_idle_pct = 22; recv_stall_pct = 22; end
            endcase
            repeat (PHASE_BEATS) send_random_beat();
            drain_results();
        end

        repeat (4) @(posedge i_clk);
        $display("Sent %0d reads, %0d writes, %0d raises and %0d no-ops %s",
                 cmd_count[ismc_pkg::CMD_READ], cmd_count[ismc_pkg::CMD_WRITE],
                 cmd_count[ismc_pkg::CMD_RAISE], cmd_count[ismc_pkg::CMD_NOP],
                 "across four idle/stall phases.");
        $display("Compared %0d result beats; %0d field mismatches.", sb.checked, sb.failures);
        if (sb.failures == 0 && sb.pending_results.size() == 0) begin
            $display("interrupt_status_mask_controller verification clean");
        end else begin
            $display("interrupt_status_mask_controller verification failed");
        end
        $finish;
    end

endmodule

### sim.f
rtl/ismc_pkg.sv
rtl/interrupt_status_mask_controller.sv
bench/tb.sv
